// ----- hw/rtl/oriented_box_footprint_sdf_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the oriented box distance block.
// ---------------------------------------------------------------------------
`ifndef ORIENTED_BOX_FOOTPRINT_SDF_ASSERT_SVH
`define ORIENTED_BOX_FOOTPRINT_SDF_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define OBFS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define OBFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/obfs_pkg.sv -----
// ---------------------------------------------------------------------------
// obfs_pkg
// Types, constants and the arctangent table of the oriented box distance block.
// ---------------------------------------------------------------------------
`default_nettype none
package obfs_pkg;

  localparam int unsigned FRAC_BITS_DEF     = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ANG_FRAC          = 30;
  localparam int unsigned ANG_W             = 42;
  localparam int unsigned XY_W              = 34;
  localparam int unsigned ATAN_ENTRIES      = 24;

  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 42'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 42'sd1686629713;

  typedef enum logic [2:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_HEADING      = 3'd2,
    CFG_BOX_WIDTH    = 3'd3,
    CFG_BOX_DEPTH    = 3'd4,
    CFG_SIZE_FLOOR   = 3'd5,
    CFG_SIZE_CEILING = 3'd6
  } cfg_idx_e;

  // Offset of the point from the box centre and the clamped extents.
  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [22:0]        w;
    logic [22:0]        d;
  } geo_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = 42'sd843314857;
      1:  r = 42'sd497837829;
      2:  r = 42'sd263043837;
      3:  r = 42'sd133525159;
      4:  r = 42'sd67021687;
      5:  r = 42'sd33543516;
      6:  r = 42'sd16775851;
      7:  r = 42'sd8388437;
      8:  r = 42'sd4194283;
      9:  r = 42'sd2097149;
      10: r = 42'sd1048576;
      11: r = 42'sd524288;
      12: r = 42'sd262144;
      13: r = 42'sd131072;
      14: r = 42'sd65536;
      15: r = 42'sd32768;
      16: r = 42'sd16384;
      17: r = 42'sd8192;
      18: r = 42'sd4096;
      19: r = 42'sd2048;
      20: r = 42'sd1024;
      21: r = 42'sd512;
      22: r = 42'sd256;
      23: r = 42'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/obfs_cordic.sv -----
// ---------------------------------------------------------------------------
// obfs_cordic
// Pipelined CORDIC rotation, one micro-rotation per register stage.
// ---------------------------------------------------------------------------
`default_nettype none
module obfs_cordic #(
  parameter int unsigned STAGES = obfs_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    valid_i,
  output logic                                         ready_o,
  input  wire logic signed [obfs_pkg::ANG_W-1:0]       z_i,
  input  wire logic                                    flip_i,
  input  wire obfs_pkg::geo_t                          geo_i,
  output logic                                         valid_o,
  input  wire logic                                    ready_i,
  output logic signed [obfs_pkg::XY_W-1:0]             x_o,
  output logic signed [obfs_pkg::XY_W-1:0]             y_o,
  output logic                                         flip_o,
  output obfs_pkg::geo_t                               geo_o
);
  import obfs_pkg::*;

  logic                    v_q    [STAGES];
  logic                    rdy    [STAGES];
  logic signed [XY_W-1:0]  x_q    [STAGES];
  logic signed [XY_W-1:0]  y_q    [STAGES];
  logic signed [ANG_W-1:0] z_q    [STAGES];
  logic                    flip_q [STAGES];
  geo_t                    geo_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_st
    logic                    vp, fp;
    logic signed [XY_W-1:0]  xp, yp, x_d, y_d;
    logic signed [ANG_W-1:0] zp, z_d;
    geo_t                    gp;

    if (k == 0) begin : g_first
      assign vp = valid_i;
      assign xp = CORDIC_GAIN;
      assign yp = '0;
      assign zp = z_i;
      assign fp = flip_i;
      assign gp = geo_i;
    end else begin : g_next
      assign vp = v_q[k-1];
      assign xp = x_q[k-1];
      assign yp = y_q[k-1];
      assign zp = z_q[k-1];
      assign fp = flip_q[k-1];
      assign gp = geo_q[k-1];
    end

    if (k == STAGES - 1) begin : g_last
      assign rdy[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end

    always_comb begin
      if (!zp[ANG_W-1]) begin
        x_d = xp - (yp >>> k);
        y_d = yp + (xp >>> k);
        z_d = zp - atan_q30(k);
      end else begin
        x_d = xp + (yp >>> k);
        y_d = yp - (xp >>> k);
        z_d = zp + atan_q30(k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        flip_q[k] <= fp;
        geo_q[k]  <= gp;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[STAGES-1];
  assign x_o     = x_q[STAGES-1];
  assign y_o     = y_q[STAGES-1];
  assign flip_o  = flip_q[STAGES-1];
  assign geo_o   = geo_q[STAGES-1];

endmodule
`default_nettype wire

// ----- hw/rtl/obfs_rot.sv -----
// ---------------------------------------------------------------------------
// obfs_rot
// Rotates the offset into the box frame and squares the outside excess.
// ---------------------------------------------------------------------------
`default_nettype none
module obfs_rot (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic signed [obfs_pkg::XY_W-1:0] x_i,
  input  wire logic signed [obfs_pkg::XY_W-1:0] y_i,
  input  wire logic                          flip_i,
  input  wire obfs_pkg::geo_t                geo_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [56:0]                        sumsq_o,
  output logic signed [28:0]                 inner_o
);
  import obfs_pkg::*;

  localparam int unsigned N = 6;

  logic v_q [N];
  logic rdy [N];

  for (genvar k = 0; k < N; k++) begin : g_ctl
    if (k == N - 1) begin : g_last
      assign rdy[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Stage 1: cosine and sine with the half-turn sign applied.
  logic signed [XY_W-1:0] cn, sn;
  logic signed [31:0]     c_q, s_q;
  geo_t                   g1_q;
  assign cn = flip_i ? -x_i : x_i;
  assign sn = flip_i ? -y_i : y_i;
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      c_q  <= cn[31:0];
      s_q  <= sn[31:0];
      g1_q <= geo_i;
    end
  end

  // Stage 2: the four products.
  logic signed [56:0] pcx_q, psy_q, psx_q, pcy_q;
  logic [22:0]        w2_q, d2_q;
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      pcx_q <= 57'(c_q * g1_q.dx);
      psy_q <= 57'(s_q * g1_q.dy);
      psx_q <= 57'(s_q * g1_q.dx);
      pcy_q <= 57'(c_q * g1_q.dy);
      w2_q  <= g1_q.w;
      d2_q  <= g1_q.d;
    end
  end

  // Stage 3: rounded local coordinates.
  logic signed [57:0] sum_x, sum_y;
  logic signed [26:0] lx_q, ly_q;
  logic [22:0]        w3_q, d3_q;
  assign sum_x = 58'(pcx_q) + 58'(psy_q) + (58'sd1 <<< (ANG_FRAC - 1));
  assign sum_y = 58'(pcy_q) - 58'(psx_q) + (58'sd1 <<< (ANG_FRAC - 1));
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      lx_q <= sum_x[56:30];
      ly_q <= sum_y[56:30];
      w3_q <= w2_q;
      d3_q <= d2_q;
    end
  end

  // Stage 4: excess over the half extents at double scale.
  logic [25:0]        ax, ay;
  logic signed [28:0] qx, qy, mx;
  logic [27:0]        ox_q, oy_q;
  logic signed [28:0] in4_q;
  assign ax = lx_q[26] ? 26'(-lx_q) : lx_q[25:0];
  assign ay = ly_q[26] ? 26'(-ly_q) : ly_q[25:0];
  assign qx = $signed({2'b00, ax, 1'b0}) - $signed({6'b0, w3_q});
  assign qy = $signed({2'b00, ay, 1'b0}) - $signed({6'b0, d3_q});
  assign mx = (qx > qy) ? qx : qy;
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      ox_q  <= (qx > 0) ? qx[27:0] : '0;
      oy_q  <= (qy > 0) ? qy[27:0] : '0;
      in4_q <= (mx > 0) ? '0 : mx;
    end
  end

  // Stage 5: squares. Stage 6: their sum.
  logic [55:0]        sqx_q, sqy_q;
  logic signed [28:0] in5_q, in6_q;
  logic [56:0]        sum_q;
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      sqx_q <= ox_q * ox_q;
      sqy_q <= oy_q * oy_q;
      in5_q <= in4_q;
    end
    if (rdy[5]) begin
      sum_q <= 57'(sqx_q) + 57'(sqy_q);
      in6_q <= in5_q;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];
  assign sumsq_o = sum_q;
  assign inner_o = in6_q;

endmodule
`default_nettype wire

// ----- hw/rtl/obfs_isqrt.sv -----
// ---------------------------------------------------------------------------
// obfs_isqrt
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none
module obfs_isqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [56:0]        n_i,
  input  wire logic signed [28:0] inner_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [57:0]             root_o,
  output logic signed [28:0]      inner_o
);

  localparam int unsigned N = 29;

  logic               v_q   [N];
  logic               rdy   [N];
  logic [57:0]        n_q   [N];
  logic [57:0]        r_q   [N];
  logic signed [28:0] in_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam logic [57:0] BIT = 58'd1 << (2 * (N - 1 - k));
    logic               vp;
    logic [57:0]        np, rp, trial;
    logic signed [28:0] ip;

    if (k == 0) begin : g_first
      assign vp = valid_i;
      assign np = {1'b0, n_i};
      assign rp = '0;
      assign ip = inner_i;
    end else begin : g_next
      assign vp = v_q[k-1];
      assign np = n_q[k-1];
      assign rp = r_q[k-1];
      assign ip = in_q[k-1];
    end

    if (k == N - 1) begin : g_last
      assign rdy[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end

    assign trial = rp + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        if (np >= trial) begin
          n_q[k] <= np - trial;
          r_q[k] <= (rp >> 1) + BIT;
        end else begin
          n_q[k] <= np;
          r_q[k] <= rp >> 1;
        end
        in_q[k] <= ip;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];
  assign root_o  = r_q[N-1];
  assign inner_o = in_q[N-1];

endmodule
`default_nettype wire

// ----- hw/rtl/oriented_box_footprint_sdf.sv -----
// ---------------------------------------------------------------------------
// oriented_box_footprint_sdf
// Signed distance from a 2D query point to a configured oriented box.
// ---------------------------------------------------------------------------
// The block takes one query point per cycle unless the output is held back
// and returns its signed distance to the box, negative inside, in the same
// Q7.16 format, clipped to 24 bits with a flag when clipping happened. It is
// a fully pipelined datapath of CORDIC_STAGES + 37 register stages (53 with
// the default settings): one entry stage, the CORDIC rotation stages, six
// rotation and squaring stages, 29 square-root stages and the output
// register. A new item may enter in every cycle in which no stall holds the
// pipeline, so the sustained rate is one item per cycle. Back-pressure on
// the output only stalls stages that hold an item, so bubbles inside the
// pipeline are squeezed out. Configuration writes are accepted in every cycle
// and should only be made while no item is in flight.
`default_nettype none
module oriented_box_footprint_sdf #(
  parameter int unsigned FRAC_BITS     = obfs_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = obfs_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  // Query points: tdata = {point_y, point_x}, point_x in bits 23:0.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,
  // Results: tdata = distance in bits 23:0; tuser = saturated.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,
  output logic             m_axis_tuser_o
);
  import obfs_pkg::*;

  `include "oriented_box_footprint_sdf_assert.svh"

  // Configuration registers; every write is taken at once.
  logic signed [23:0] center_x_q, center_y_q;
  logic signed [18:0] heading_q;
  logic [22:0]        box_width_q, box_depth_q, size_floor_q, size_ceiling_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      center_y_q     <= '0;
      heading_q      <= '0;
      box_width_q    <= 23'd65536;
      box_depth_q    <= 23'd65536;
      size_floor_q   <= '0;
      size_ceiling_q <= 23'd8388607;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER_X:     center_x_q     <= cfg_data_i;
        CFG_CENTER_Y:     center_y_q     <= cfg_data_i;
        CFG_HEADING:      heading_q      <= cfg_data_i[18:0];
        CFG_BOX_WIDTH:    box_width_q    <= cfg_data_i[22:0];
        CFG_BOX_DEPTH:    box_depth_q    <= cfg_data_i[22:0];
        CFG_SIZE_FLOOR:   size_floor_q   <= cfg_data_i[22:0];
        CFG_SIZE_CEILING: size_ceiling_q <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // Entry stage: offset from the centre, clamped extents and the heading
  // reduced into the half plane that CORDIC converges in. When the heading
  // lies beyond a quarter turn either way, half a turn is taken off or added
  // and the cosine and sine are negated at the end.
  function automatic logic [22:0] clamp_size(input logic [22:0] v,
                                             input logic [22:0] lo,
                                             input logic [22:0] hi);
    logic [22:0] r;
    r = (v < lo) ? lo : v;
    return (r > hi) ? hi : r;
  endfunction

  logic signed [ANG_W-1:0] z_raw, z_red;
  logic                    flip;
  geo_t                    geo_d, geo_q;
  logic signed [ANG_W-1:0] z_q;
  logic                    flip_q, v0_q, rdy0;
  logic                    cor_ready;

  assign z_raw = ANG_W'(heading_q) <<< (ANG_FRAC - FRAC_BITS);

  always_comb begin
    flip  = 1'b0;
    z_red = z_raw;
    if (z_raw > HALF_PI_Q30) begin
      z_red = z_raw - PI_Q30;
      flip  = 1'b1;
    end else if (z_raw < -HALF_PI_Q30) begin
      z_red = z_raw + PI_Q30;
      flip  = 1'b1;
    end
    geo_d.dx = 25'($signed(s_axis_tdata_i[23:0])) - 25'(center_x_q);
    geo_d.dy = 25'($signed(s_axis_tdata_i[47:24])) - 25'(center_y_q);
    geo_d.w  = clamp_size(box_width_q, size_floor_q, size_ceiling_q);
    geo_d.d  = clamp_size(box_depth_q, size_floor_q, size_ceiling_q);
  end

  assign rdy0            = !v0_q || cor_ready;
  assign s_axis_tready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      geo_q  <= geo_d;
      z_q    <= z_red;
      flip_q <= flip;
    end
  end

  // CORDIC cosine and sine of the reduced heading.
  logic signed [XY_W-1:0] cx, cy;
  logic                   cflip, cv, rot_ready;
  geo_t                   cgeo;

  obfs_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .ready_o (cor_ready),
    .z_i     (z_q),
    .flip_i  (flip_q),
    .geo_i   (geo_q),
    .valid_o (cv),
    .ready_i (rot_ready),
    .x_o     (cx),
    .y_o     (cy),
    .flip_o  (cflip),
    .geo_o   (cgeo)
  );

  // Rotation into the box frame and sum of the squared outside excess.
  logic [56:0]        sumsq;
  logic signed [28:0] rinner;
  logic               rv, sq_ready;

  obfs_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv),
    .ready_o (rot_ready),
    .x_i     (cx),
    .y_i     (cy),
    .flip_i  (cflip),
    .geo_i   (cgeo),
    .valid_o (rv),
    .ready_i (sq_ready),
    .sumsq_o (sumsq),
    .inner_o (rinner)
  );

  // Floor square root of the sum of squares.
  logic [57:0]        root;
  logic signed [28:0] sinner;
  logic               sv, out_rdy;

  obfs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv),
    .ready_o (sq_ready),
    .n_i     (sumsq),
    .inner_i (rinner),
    .valid_o (sv),
    .ready_i (out_rdy),
    .root_o  (root),
    .inner_o (sinner)
  );

  // Output stage: halve with rounding half up, then clip to 24 bits.
  logic signed [31:0] total, dist_v;
  logic               sat;
  logic [23:0]        dist_q;
  logic               sat_q, vo_q;
  logic [23:0]        dist_q_d;

  assign total  = $signed({2'b00, root[29:0]}) + 32'(sinner) + 32'sd1;
  assign dist_v = total >>> 1;

  always_comb begin
    sat = 1'b1;
    if (dist_v > 32'sd8388607) begin
      dist_q_d = 24'h7FFFFF;
    end else if (dist_v < -32'sd8388608) begin
      dist_q_d = 24'h800000;
    end else begin
      dist_q_d = dist_v[23:0];
      sat      = 1'b0;
    end
  end

  assign out_rdy = !vo_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (out_rdy) begin
      vo_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      dist_q <= dist_q_d;
      sat_q  <= sat;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = dist_q;
  assign m_axis_tuser_o  = sat_q;

  // A clipped result always sits at one end of the range.
  `OBFS_ASSERT_IMP(a_sat_at_limit, m_axis_tvalid_o && m_axis_tuser_o,
    m_axis_tdata_o == 24'h7FFFFF || m_axis_tdata_o == 24'h800000, "clipped result off limit")
  // The input only stalls when the output is held back.
  `OBFS_ASSERT_IMP(a_stall_origin, !s_axis_tready_o,
    m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output back-pressure")
  // The root of a 57-bit sum never reaches 2^29.
  `OBFS_ASSERT_IMP(a_root_range, sv, root[57:29] == '0, "square root out of range")

endmodule
`default_nettype wire
